[rtl/sftr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scaled font text rasterizer package
// Shared widths, codes, interface structures and the 5x7 glyph ROM.
// ----------------------------------------------------------------------------
package sftr_pkg;

  localparam int unsigned CURSOR_BITS = 24;
  localparam int unsigned COORD_BITS  = 15;
  localparam int unsigned COLOR_BITS  = 32;
  localparam int unsigned SCALE_BITS  = 4;
  localparam int unsigned CODE_BITS   = 8;
  localparam int unsigned ORIGIN_BITS = 16;
  localparam int unsigned CFG_BITS    = 32;
  localparam int unsigned CFG_IDX_BITS = 2;
  localparam int unsigned GLYPH_DOTS  = 35;
  localparam int unsigned GLYPH_COLS  = 5;
  localparam int unsigned DOT_BITS    = 6;
  localparam int unsigned COL_BITS    = 3;

  localparam logic [CODE_BITS-1:0]  NEWLINE_CODE = 8'd10;
  localparam logic [COORD_BITS-1:0] FRAME_WIDTH_RESET  = 15'd640;
  localparam logic [COORD_BITS-1:0] FRAME_HEIGHT_RESET = 15'd480;
  localparam logic [SCALE_BITS-1:0] PIXEL_SCALE_RESET  = 4'd1;
  localparam logic [COLOR_BITS-1:0] INK_COLOR_RESET    = 32'hFFFF_FFFF;

  typedef logic [CURSOR_BITS-1:0] cursor_t;
  typedef logic [COORD_BITS-1:0]  coord_t;
  typedef logic [GLYPH_DOTS-1:0]  glyph_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_SCAN,
    SEQ_FLUSH
  } seq_state_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_PIXEL_SCALE  = 2'd2,
    REG_INK_COLOR    = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    cursor_t col_x;
    cursor_t row_y;
  } cell_req_t;

  typedef struct packed {
    coord_t left;
    coord_t top;
    coord_t right;
    coord_t bottom;
  } cell_edges_t;

  typedef struct packed {
    cell_edges_t edges;
    logic        hit;
    cursor_t     right_raw;
    cursor_t     bottom_raw;
  } cell_rsp_t;

  typedef struct packed {
    logic        valid;
    cell_edges_t edges;
    logic        last;
  } cell_push_t;

  typedef struct packed {
    logic busy;
    logic pend_valid;
  } seq_status_t;

  // Rows top to bottom, leftmost dot in the most significant bit of each row.
  function automatic glyph_t glyph_bits(input logic [CODE_BITS-1:0] code);
    glyph_t g;
    case (code)
      8'h41: g = {5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
      8'h42: g = {5'd30, 5'd17, 5'd17, 5'd30, 5'd17, 5'd17, 5'd30};
      8'h43: g = {5'd15, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd15};
      8'h44: g = {5'd30, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd30};
      8'h45: g = {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31};
      8'h46: g = {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd16};
      8'h47: g = {5'd15, 5'd16, 5'd16, 5'd23, 5'd17, 5'd17, 5'd15};
      8'h48: g = {5'd17, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
      8'h49: g = {5'd31, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd31};
      8'h4A: g = {5'd7,  5'd2,  5'd2,  5'd2,  5'd18, 5'd18, 5'd12};
      8'h4B: g = {5'd17, 5'd18, 5'd20, 5'd24, 5'd20, 5'd18, 5'd17};
      8'h4C: g = {5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd31};
      8'h4D: g = {5'd17, 5'd27, 5'd21, 5'd21, 5'd17, 5'd17, 5'd17};
      8'h4E: g = {5'd17, 5'd25, 5'd21, 5'd19, 5'd17, 5'd17, 5'd17};
      8'h4F: g = {5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
      8'h50: g = {5'd30, 5'd17, 5'd17, 5'd30, 5'd16, 5'd16, 5'd16};
      8'h51: g = {5'd14, 5'd17, 5'd17, 5'd17, 5'd21, 5'd18, 5'd13};
      8'h52: g = {5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17};
      8'h53: g = {5'd15, 5'd16, 5'd16, 5'd14, 5'd1,  5'd1,  5'd30};
      8'h54: g = {5'd31, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4};
      8'h55: g = {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
      8'h56: g = {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd10, 5'd4};
      8'h57: g = {5'd17, 5'd17, 5'd17, 5'd21, 5'd21, 5'd27, 5'd17};
      8'h58: g = {5'd17, 5'd17, 5'd10, 5'd4,  5'd10, 5'd17, 5'd17};
      8'h59: g = {5'd17, 5'd17, 5'd10, 5'd4,  5'd4,  5'd4,  5'd4};
      8'h5A: g = {5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd16, 5'd31};
      8'h30: g = {5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14};
      8'h31: g = {5'd4,  5'd12, 5'd4,  5'd4,  5'd4,  5'd4,  5'd14};
      8'h32: g = {5'd14, 5'd17, 5'd1,  5'd2,  5'd4,  5'd8,  5'd31};
      8'h33: g = {5'd30, 5'd1,  5'd1,  5'd14, 5'd1,  5'd1,  5'd30};
      8'h34: g = {5'd2,  5'd6,  5'd10, 5'd18, 5'd31, 5'd2,  5'd2};
      8'h35: g = {5'd31, 5'd16, 5'd16, 5'd30, 5'd1,  5'd1,  5'd30};
      8'h36: g = {5'd14, 5'd16, 5'd16, 5'd30, 5'd17, 5'd17, 5'd14};
      8'h37: g = {5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd8,  5'd8};
      8'h38: g = {5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14};
      8'h39: g = {5'd14, 5'd17, 5'd17, 5'd15, 5'd1,  5'd1,  5'd14};
      8'h2E: g = {5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd6,  5'd6};
      8'h3A: g = {5'd0,  5'd6,  5'd6,  5'd0,  5'd6,  5'd6,  5'd0};
      8'h25: g = {5'd24, 5'd25, 5'd2,  5'd4,  5'd8,  5'd19, 5'd3};
      8'h2D: g = {5'd0,  5'd0,  5'd0,  5'd31, 5'd0,  5'd0,  5'd0};
      8'h2B: g = {5'd0,  5'd4,  5'd4,  5'd31, 5'd4,  5'd4,  5'd0};
      8'h5F: g = {5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd31};
      8'h2F: g = {5'd1,  5'd2,  5'd2,  5'd4,  5'd8,  5'd8,  5'd16};
      8'h21: g = {5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd0,  5'd4};
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

[rtl/sftr_cell_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scaled font text rasterizer cell unit
// Shared adder and clip stage: forms the far edges of one glyph cell and
// clamps the left, top, right and bottom edges to the frame.
// ----------------------------------------------------------------------------
module sftr_cell_unit (
  input  sftr_pkg::cell_req_t                  req_i,
  input  logic [sftr_pkg::SCALE_BITS-1:0]      pixel_scale_i,
  input  sftr_pkg::coord_t                     frame_width_i,
  input  sftr_pkg::coord_t                     frame_height_i,
  output sftr_pkg::cell_rsp_t                  rsp_o
);

  function automatic sftr_pkg::coord_t clip_edge(input sftr_pkg::cursor_t v,
                                                 input sftr_pkg::coord_t limit);
    sftr_pkg::coord_t r;
    if (v[sftr_pkg::CURSOR_BITS-1]) begin
      r = '0;
    end else if (v > {{(sftr_pkg::CURSOR_BITS-sftr_pkg::COORD_BITS){1'b0}}, limit}) begin
      r = limit;
    end else begin
      r = v[sftr_pkg::COORD_BITS-1:0];
    end
    return r;
  endfunction

  sftr_pkg::cursor_t scale_ext;
  sftr_pkg::cursor_t right_raw;
  sftr_pkg::cursor_t bottom_raw;
  sftr_pkg::cell_edges_t edges;

  assign scale_ext  = {{(sftr_pkg::CURSOR_BITS-sftr_pkg::SCALE_BITS){1'b0}}, pixel_scale_i};
  assign right_raw  = req_i.col_x + scale_ext;
  assign bottom_raw = req_i.row_y + scale_ext;

  always_comb begin
    edges.left   = clip_edge(req_i.col_x, frame_width_i);
    edges.right  = clip_edge(right_raw, frame_width_i);
    edges.top    = clip_edge(req_i.row_y, frame_height_i);
    edges.bottom = clip_edge(bottom_raw, frame_height_i);
  end

  assign rsp_o.edges      = edges;
  assign rsp_o.hit        = (edges.left < edges.right) && (edges.top < edges.bottom);
  assign rsp_o.right_raw  = right_raw;
  assign rsp_o.bottom_raw = bottom_raw;

endmodule

[rtl/sftr_sequencer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scaled font text rasterizer sequencer
// Holds the cursor, walks the 35 glyph dots through the cell unit and keeps
// one cell back so that the final cell of a character can be marked.
// ----------------------------------------------------------------------------
module sftr_sequencer (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [sftr_pkg::CODE_BITS-1:0]        char_code_i,
  input  logic                                  string_start_i,
  input  logic signed [sftr_pkg::ORIGIN_BITS-1:0] origin_x_i,
  input  logic signed [sftr_pkg::ORIGIN_BITS-1:0] origin_y_i,
  input  logic [sftr_pkg::SCALE_BITS-1:0]       pixel_scale_i,
  output sftr_pkg::cell_req_t                   req_o,
  input  sftr_pkg::cell_rsp_t                   rsp_i,
  input  logic                                  out_free_i,
  output sftr_pkg::cell_push_t                  push_o,
  output sftr_pkg::seq_status_t                 status_o
);

  localparam logic [sftr_pkg::DOT_BITS-1:0] DotLast = sftr_pkg::DOT_BITS'(sftr_pkg::GLYPH_DOTS-1);
  localparam logic [sftr_pkg::COL_BITS-1:0] ColLast = sftr_pkg::COL_BITS'(sftr_pkg::GLYPH_COLS-1);

  sftr_pkg::seq_state_e state_q, state_d;
  sftr_pkg::cursor_t cursor_x_q, cursor_x_d;
  sftr_pkg::cursor_t cursor_y_q, cursor_y_d;
  sftr_pkg::cursor_t line_start_q, line_start_d;
  sftr_pkg::cursor_t col_x_q, col_x_d;
  sftr_pkg::cursor_t row_y_q, row_y_d;
  sftr_pkg::glyph_t glyph_q, glyph_d;
  logic [sftr_pkg::DOT_BITS-1:0] dot_q, dot_d;
  logic [sftr_pkg::COL_BITS-1:0] col_q, col_d;
  logic pend_valid_q, pend_valid_d;
  sftr_pkg::cell_edges_t pend_q, pend_d;

  sftr_pkg::cursor_t org_x, org_y, load_x, load_y, load_line;
  sftr_pkg::cursor_t step_x, step_y;
  logic hit;

  assign org_x = {{(sftr_pkg::CURSOR_BITS-sftr_pkg::ORIGIN_BITS){origin_x_i[sftr_pkg::ORIGIN_BITS-1]}},
                  origin_x_i};
  assign org_y = {{(sftr_pkg::CURSOR_BITS-sftr_pkg::ORIGIN_BITS){origin_y_i[sftr_pkg::ORIGIN_BITS-1]}},
                  origin_y_i};
  assign load_x    = string_start_i ? org_x : cursor_x_q;
  assign load_line = string_start_i ? org_x : line_start_q;
  assign load_y    = string_start_i ? org_y : cursor_y_q;

  // Six and nine times the scale, built from shifts.
  assign step_x = {{(sftr_pkg::CURSOR_BITS-7){1'b0}},
                   ({1'b0, pixel_scale_i, 2'b00} + {2'b00, pixel_scale_i, 1'b0})};
  assign step_y = {{(sftr_pkg::CURSOR_BITS-8){1'b0}},
                   ({1'b0, pixel_scale_i, 3'b000} + {4'b0000, pixel_scale_i})};

  assign req_o.col_x = col_x_q;
  assign req_o.row_y = row_y_q;
  assign hit = glyph_q[sftr_pkg::GLYPH_DOTS-1] && rsp_i.hit;

  assign in_stall_o          = (state_q != sftr_pkg::SEQ_IDLE);
  assign status_o.busy       = (state_q != sftr_pkg::SEQ_IDLE);
  assign status_o.pend_valid = pend_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sftr_pkg::SEQ_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_x_q   <= '0;
      cursor_y_q   <= '0;
      line_start_q <= '0;
      pend_valid_q <= 1'b0;
    end else begin
      cursor_x_q   <= cursor_x_d;
      cursor_y_q   <= cursor_y_d;
      line_start_q <= line_start_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    col_x_q <= col_x_d;
    row_y_q <= row_y_d;
    glyph_q <= glyph_d;
    dot_q   <= dot_d;
    col_q   <= col_d;
    pend_q  <= pend_d;
  end

  always_comb begin
    state_d      = state_q;
    cursor_x_d   = cursor_x_q;
    cursor_y_d   = cursor_y_q;
    line_start_d = line_start_q;
    col_x_d      = col_x_q;
    row_y_d      = row_y_q;
    glyph_d      = glyph_q;
    dot_d        = dot_q;
    col_d        = col_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    push_o.valid = 1'b0;
    push_o.edges = pend_q;
    push_o.last  = 1'b0;

    case (state_q)
      sftr_pkg::SEQ_IDLE: begin
        if (in_valid_i) begin
          line_start_d = load_line;
          if (char_code_i == sftr_pkg::NEWLINE_CODE) begin
            cursor_x_d = load_line;
            cursor_y_d = load_y + step_y;
          end else begin
            cursor_x_d   = load_x;
            cursor_y_d   = load_y;
            col_x_d      = load_x;
            row_y_d      = load_y;
            glyph_d      = sftr_pkg::glyph_bits(char_code_i);
            dot_d        = '0;
            col_d        = '0;
            pend_valid_d = 1'b0;
            state_d      = sftr_pkg::SEQ_SCAN;
          end
        end
      end
      sftr_pkg::SEQ_SCAN: begin
        if (!(hit && pend_valid_q && !out_free_i)) begin
          glyph_d = glyph_q << 1;
          dot_d   = dot_q + 1'b1;
          if (col_q == ColLast) begin
            col_d   = '0;
            col_x_d = cursor_x_q;
            row_y_d = rsp_i.bottom_raw;
          end else begin
            col_d   = col_q + 1'b1;
            col_x_d = rsp_i.right_raw;
          end
          if (hit) begin
            push_o.valid = pend_valid_q;
            pend_d       = rsp_i.edges;
            pend_valid_d = 1'b1;
          end
          if (dot_q == DotLast) begin
            state_d = sftr_pkg::SEQ_FLUSH;
          end
        end
      end
      sftr_pkg::SEQ_FLUSH: begin
        if (!pend_valid_q || out_free_i) begin
          push_o.valid = pend_valid_q;
          push_o.last  = 1'b1;
          pend_valid_d = 1'b0;
          cursor_x_d   = cursor_x_q + step_x;
          state_d      = sftr_pkg::SEQ_IDLE;
        end
      end
      default: begin
        state_d = sftr_pkg::SEQ_IDLE;
      end
    endcase
  end

endmodule

[rtl/scaled_font_text_rasterizer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scaled font text rasterizer
// Turns characters into clipped, scaled cell rectangles of a 5x7 font.
// ----------------------------------------------------------------------------
// One character is transferred on the input channel (in_valid_i, in_stall_o)
// together with a string start flag and the string origin. Each set dot of
// its glyph yields one cell rectangle on the output channel (out_valid_o,
// out_stall_i), clipped to the frame; the final cell of a character carries
// last_cell_o. Empty cells, unknown codes and newlines give no transfer.
// A printable or unknown character keeps the block busy: it is accepted,
// its 35 glyph dots are walked through the shared adder and clip unit one
// after another, and then the held-back final cell is handed over and the
// cursor advanced. A newline moves the cursor to the start of the next
// line and the block stays idle. One cell is always held back until the
// next is found. When a new cell is found, or the final cell is due, while
// a cell is held back and the output register is full and stalled, the
// block waits. Configuration writes (cfg_we_i, cfg_index_i, cfg_data_i)
// take effect at once; the user must make them only while the block is
// idle, and the block itself does not enforce this. Reset clears the
// cursor, line start and all valid flags and loads the register defaults.
// ----------------------------------------------------------------------------
module scaled_font_text_rasterizer (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [sftr_pkg::CFG_IDX_BITS-1:0]       cfg_index_i,
  input  logic [sftr_pkg::CFG_BITS-1:0]           cfg_data_i,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic [sftr_pkg::CODE_BITS-1:0]          char_code_i,
  input  logic                                    string_start_i,
  input  logic signed [sftr_pkg::ORIGIN_BITS-1:0] origin_x_i,
  input  logic signed [sftr_pkg::ORIGIN_BITS-1:0] origin_y_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic [sftr_pkg::COORD_BITS-1:0]         cell_left_o,
  output logic [sftr_pkg::COORD_BITS-1:0]         cell_top_o,
  output logic [sftr_pkg::COORD_BITS-1:0]         cell_right_o,
  output logic [sftr_pkg::COORD_BITS-1:0]         cell_bottom_o,
  output logic [sftr_pkg::COLOR_BITS-1:0]         cell_color_o,
  output logic                                    last_cell_o
);

  sftr_pkg::coord_t frame_width_q, frame_height_q;
  logic [sftr_pkg::SCALE_BITS-1:0] pixel_scale_q;
  logic [sftr_pkg::COLOR_BITS-1:0] ink_color_q;

  logic out_valid_q, out_valid_d;
  sftr_pkg::cell_edges_t out_edges_q;
  logic [sftr_pkg::COLOR_BITS-1:0] out_color_q;
  logic out_last_q;

  sftr_pkg::cell_req_t   req;
  sftr_pkg::cell_rsp_t   rsp;
  sftr_pkg::cell_push_t  push;
  sftr_pkg::seq_status_t status;
  logic out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= sftr_pkg::FRAME_WIDTH_RESET;
      frame_height_q <= sftr_pkg::FRAME_HEIGHT_RESET;
      pixel_scale_q  <= sftr_pkg::PIXEL_SCALE_RESET;
      ink_color_q    <= sftr_pkg::INK_COLOR_RESET;
    end else if (cfg_we_i) begin
      case (sftr_pkg::cfg_reg_e'(cfg_index_i))
        sftr_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[sftr_pkg::COORD_BITS-1:0];
        sftr_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[sftr_pkg::COORD_BITS-1:0];
        sftr_pkg::REG_PIXEL_SCALE:  pixel_scale_q  <= cfg_data_i[sftr_pkg::SCALE_BITS-1:0];
        sftr_pkg::REG_INK_COLOR:    ink_color_q    <= cfg_data_i[sftr_pkg::COLOR_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  sftr_sequencer u_sequencer (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .char_code_i    (char_code_i),
    .string_start_i (string_start_i),
    .origin_x_i     (origin_x_i),
    .origin_y_i     (origin_y_i),
    .pixel_scale_i  (pixel_scale_q),
    .req_o          (req),
    .rsp_i          (rsp),
    .out_free_i     (out_free),
    .push_o         (push),
    .status_o       (status)
  );

  sftr_cell_unit u_cell_unit (
    .req_i          (req),
    .pixel_scale_i  (pixel_scale_q),
    .frame_width_i  (frame_width_q),
    .frame_height_i (frame_height_q),
    .rsp_o          (rsp)
  );

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (push.valid) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push.valid) begin
      out_edges_q <= push.edges;
      out_color_q <= ink_color_q;
      out_last_q  <= push.last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign cell_left_o   = out_edges_q.left;
  assign cell_top_o    = out_edges_q.top;
  assign cell_right_o  = out_edges_q.right;
  assign cell_bottom_o = out_edges_q.bottom;
  assign cell_color_o  = out_color_q;
  assign last_cell_o   = out_last_q;

  a_push_into_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.valid |-> out_free)
    else $error("A cell was handed over while the output register was occupied.");

  a_cell_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((cell_left_o < cell_right_o) && (cell_top_o < cell_bottom_o)))
    else $error("An empty cell was presented on the output.");

  a_idle_no_held_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !status.busy |-> !status.pend_valid)
    else $error("A held-back cell remained while the block was idle.");

  a_glyph_starts_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (char_code_i != sftr_pkg::NEWLINE_CODE)) |=> in_stall_o)
    else $error("A character transfer did not start the glyph walk.");

endmodule
